/* rtl/core/cac_pkg.sv */
// Package with shared types, constants and helpers of the row color fringe corrector.
package cac_pkg;

  // Row storage depth and derived widths.
  localparam int unsigned MAX_WIDTH = 1024;
  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned PW = $clog2(MAX_WIDTH + 1);

  // Command codes.
  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_CORRECT = 2'd1,
    CMD_READ    = 2'd2,
    CMD_NONE    = 2'd3
  } cac_cmd_e;

  // Configuration register indexes.
  localparam logic CFG_EDGE_THRESHOLD = 1'b0;
  localparam logic CFG_ROW_WIDTH      = 1'b1;

  typedef struct packed {
    logic [1:0] command;
    logic [9:0] pixel_index;
    logic [7:0] blue_in;
    logic [7:0] green_in;
    logic [7:0] red_in;
  } cac_in_t;

  typedef struct packed {
    logic [7:0] blue_out;
    logic [7:0] green_out;
    logic [7:0] red_out;
  } cac_out_t;

  // One stored pixel.
  typedef struct packed {
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } cac_pix_t;

  // Color difference limits taken at the two range ends.
  typedef struct packed {
    logic signed [9:0] bmax;
    logic signed [9:0] bmin;
    logic signed [9:0] rmax;
    logic signed [9:0] rmin;
  } cac_bounds_t;

  // Signed difference a - c of two samples.
  function automatic logic signed [9:0] diff8(input logic [7:0] a, input logic [7:0] c);
    return $signed({2'b00, a}) - $signed({2'b00, c});
  endfunction

endpackage

/* rtl/core/cac_ram.sv */
// Generic single-port RAM with registered read data.
module cac_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write on enable, read every cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

/* rtl/core/cac_grad.sv */
// Shared gradient unit: central gradients of two neighbor pixels against the threshold.
module cac_grad (
  input  cac_pkg::cac_pix_t         prev_i,
  input  cac_pkg::cac_pix_t         next_i,
  input  logic                      pos_i,
  input  logic [8:0]                thresh_i,
  output logic signed [9:0]         green_diff_o,
  output logic                      edge_o,
  output logic                      extend_o
);
  import cac_pkg::*;

  logic signed [9:0]  db, dg, dr;
  logic signed [10:0] sb, sg, sr, th, ag;

  assign db = diff8(next_i.b, prev_i.b);
  assign dg = diff8(next_i.g, prev_i.g);
  assign dr = diff8(next_i.r, prev_i.r);
  assign th = $signed({2'b00, thresh_i});

  // Gradients taken with the sign of the edge.
  assign sb = pos_i ? 11'(db) : -11'(db);
  assign sg = pos_i ? 11'(dg) : -11'(dg);
  assign sr = pos_i ? 11'(dr) : -11'(dr);
  assign ag = (dg < 0) ? -11'(dg) : 11'(dg);

  assign green_diff_o = dg;
  assign edge_o       = ag >= th;
  assign extend_o     = (sg >= th) || (sb >= th) || (sr >= th);

endmodule

/* rtl/core/cac_clamp.sv */
// Clamps the blue and red differences of one pixel to the range limits.
module cac_clamp (
  input  cac_pkg::cac_pix_t    pix_i,
  input  cac_pkg::cac_bounds_t bnd_i,
  output cac_pkg::cac_pix_t    pix_o
);
  import cac_pkg::*;

  logic signed [9:0] bd, rd;

  function automatic logic [7:0] sat_add(input logic signed [9:0] d, input logic [7:0] g);
    logic signed [10:0] s;
    s = 11'(d) + $signed({3'b000, g});
    if (s < 0) return 8'd0;
    if (s > 11'sd255) return 8'd255;
    return s[7:0];
  endfunction

  assign bd = diff8(pix_i.b, pix_i.g);
  assign rd = diff8(pix_i.r, pix_i.g);

  // Green passes unchanged; blue and red pull back into the limits.
  always_comb begin
    pix_o = pix_i;
    if (bd > bnd_i.bmax) begin
      pix_o.b = sat_add(bnd_i.bmax, pix_i.g);
    end else if (bd < bnd_i.bmin) begin
      pix_o.b = sat_add(bnd_i.bmin, pix_i.g);
    end
    if (rd > bnd_i.rmax) begin
      pix_o.r = sat_add(bnd_i.rmax, pix_i.g);
    end else if (rd < bnd_i.rmin) begin
      pix_o.r = sat_add(bnd_i.rmin, pix_i.g);
    end
  end

endmodule

/* rtl/core/chromatic_aberration_row_correct.sv */
// Top level of the row color fringe corrector: sequencer, row RAM and shared units.
//
// Usage. One request channel (in_valid_i / in_ready_o, payload in_req_i) takes
// commands: write a pixel, run correction over the row, or read a pixel. Reads
// answer on the result channel (out_valid_o / out_ready_i, payload out_rsp_o).
// A write goes straight into the RAM. A read passes through the RAM read
// register and the S_RD state; its result sits in an output register until
// taken, and the next request waits while it is held. Correction walks the
// row with one single-port RAM and one gradient unit: each scanned pixel
// steps through S_E0 to S_E2, each range step in either direction through
// S_L0 to S_L2 or S_H0 to S_H2, the range ends are fetched in S_B0 to S_B2
// and each pixel in the range is read in S_K0 and rewritten in S_K1. The
// request channel is not ready until the walk ends. Configuration writes
// through cfg_we_i land at once. Reset clears the sequencer and loads
// threshold 30 and width 1024; row contents are undefined until written. A
// stalled receiver only holds the read result; nothing is lost.
module chromatic_aberration_row_correct (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  cac_pkg::cac_in_t in_req_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output cac_pkg::cac_out_t out_rsp_o,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [10:0]      cfg_wdata_i
);
  import cac_pkg::*;

  typedef enum logic [15:0] {
    S_IDLE = 16'h0001, S_RD = 16'h0002,
    S_E0 = 16'h0004, S_E1 = 16'h0008, S_E2 = 16'h0010,
    S_L0 = 16'h0020, S_L1 = 16'h0040, S_L2 = 16'h0080,
    S_H0 = 16'h0100, S_H1 = 16'h0200, S_H2 = 16'h0400,
    S_B0 = 16'h0800, S_B1 = 16'h1000, S_B2 = 16'h2000,
    S_K0 = 16'h4000, S_K1 = 16'h8000
  } state_e;

  state_e state_q, state_d;
  logic [8:0]  thresh_q;
  logic [10:0] width_q;
  logic [PW-1:0] w_q, w_d, j_q, j_d, lo_q, lo_d, hi_q, hi_d, k_q, k_d;
  logic        pos_q, pos_d;
  logic        oob_q, oob_d;
  cac_pix_t    a_q, a_d;
  cac_bounds_t bnd_q, bnd_d;
  logic        out_valid_q, out_valid_d;
  cac_out_t    out_q, out_d;

  logic          accept, idx_ok;
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  cac_pix_t      ram_wdata, ram_rdata, fixed_pix;
  logic signed [9:0] gdiff;
  logic          is_edge, extend;
  logic [PW-1:0] w_eff, l_pos, r_pos, wm1;
  logic signed [9:0] bl, br, rl, rr;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE) && !out_valid_q;
  assign idx_ok     = 32'(in_req_i.pixel_index) < MAX_WIDTH;
  assign w_eff      = (32'(width_q) > MAX_WIDTH) ? PW'(MAX_WIDTH) : PW'(width_q);
  assign wm1        = w_q - PW'(1);
  assign l_pos      = (lo_q == '0) ? '0 : lo_q - PW'(1);
  assign r_pos      = (hi_q == wm1) ? hi_q : hi_q + PW'(1);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q <= 9'd30;
      width_q  <= 11'd1024;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_EDGE_THRESHOLD: thresh_q <= cfg_wdata_i[8:0];
        CFG_ROW_WIDTH:      width_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Row storage, one word per pixel.
  cac_ram #(.WIDTH($bits(cac_pix_t)), .DEPTH(MAX_WIDTH)) u_row (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  cac_grad u_grad (
    .prev_i       (a_q),
    .next_i       (ram_rdata),
    .pos_i        (pos_q),
    .thresh_i     (thresh_q),
    .green_diff_o (gdiff),
    .edge_o       (is_edge),
    .extend_o     (extend)
  );

  cac_clamp u_clamp (
    .pix_i (ram_rdata),
    .bnd_i (bnd_q),
    .pix_o (fixed_pix)
  );

  // Differences at the two range ends.
  assign bl = diff8(a_q.b, a_q.g);
  assign rl = diff8(a_q.r, a_q.g);
  assign br = diff8(ram_rdata.b, ram_rdata.g);
  assign rr = diff8(ram_rdata.r, ram_rdata.g);

  // RAM port selection.
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = '0;
    ram_wdata = fixed_pix;
    case (state_q)
      S_IDLE: begin
        ram_addr  = AW'(in_req_i.pixel_index);
        ram_wdata = '{b: in_req_i.blue_in, g: in_req_i.green_in, r: in_req_i.red_in};
        ram_we    = accept && (in_req_i.command == CMD_WRITE) && idx_ok;
      end
      S_E0: ram_addr = AW'(j_q - PW'(1));
      S_E1: ram_addr = AW'(j_q + PW'(1));
      S_L0: ram_addr = AW'(lo_q - PW'(1));
      S_L1: ram_addr = AW'(lo_q + PW'(1));
      S_H0: ram_addr = AW'(hi_q - PW'(1));
      S_H1: ram_addr = AW'(hi_q + PW'(1));
      S_B0: ram_addr = AW'(l_pos);
      S_B1: ram_addr = AW'(r_pos);
      S_K0: ram_addr = AW'(k_q);
      S_K1: begin
        ram_addr = AW'(k_q);
        ram_we   = 1'b1;
      end
      default: ;
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    w_d         = w_q;
    j_d         = j_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    k_d         = k_q;
    pos_d       = pos_q;
    oob_d       = oob_q;
    a_d         = a_q;
    bnd_d       = bnd_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_req_i.command)
            CMD_READ: begin
              oob_d   = !idx_ok;
              state_d = S_RD;
            end
            CMD_CORRECT: begin
              w_d = w_eff;
              j_d = PW'(1);
              if (w_eff >= PW'(3)) state_d = S_E0;
            end
            default: ;
          endcase
        end
      end
      S_RD: begin
        out_valid_d = 1'b1;
        out_d = oob_q ? cac_out_t'('0)
                      : cac_out_t'{blue_out: ram_rdata.b, green_out: ram_rdata.g,
                                   red_out: ram_rdata.r};
        state_d = S_IDLE;
      end
      S_E0, S_L0, S_H0, S_B0, S_K0: begin
        if (state_q == S_B0) k_d = l_pos;
        state_d = state_e'({state_q[14:0], 1'b0});
      end
      S_E1, S_L1, S_H1, S_B1: begin
        a_d     = ram_rdata;
        state_d = state_e'({state_q[14:0], 1'b0});
      end
      S_E2: begin
        if (is_edge) begin
          pos_d = gdiff > 0;
          lo_d  = j_q - PW'(1);
          hi_d  = j_q + PW'(1);
          if (j_q > PW'(1)) state_d = S_L0;
          else if (j_q + PW'(1) < wm1) state_d = S_H0;
          else state_d = S_B0;
        end else begin
          j_d = j_q + PW'(1);
          state_d = (j_q + PW'(1) < wm1) ? S_E0 : S_IDLE;
        end
      end
      S_L2: begin
        if (extend && (lo_q > PW'(1))) begin
          lo_d    = lo_q - PW'(1);
          state_d = S_L0;
        end else begin
          if (extend) lo_d = lo_q - PW'(1);
          state_d = (hi_q < wm1) ? S_H0 : S_B0;
        end
      end
      S_H2: begin
        if (extend) begin
          hi_d    = hi_q + PW'(1);
          state_d = (hi_q + PW'(1) < wm1) ? S_H0 : S_B0;
        end else begin
          state_d = S_B0;
        end
      end
      S_B2: begin
        bnd_d.bmax = (bl > br) ? bl : br;
        bnd_d.bmin = (bl < br) ? bl : br;
        bnd_d.rmax = (rl > rr) ? rl : rr;
        bnd_d.rmin = (rl < rr) ? rl : rr;
        state_d    = S_K0;
      end
      S_K1: begin
        if (k_q == r_pos) begin
          j_d     = hi_q;
          state_d = (hi_q < wm1) ? S_E0 : S_IDLE;
        end else begin
          k_d     = k_q + PW'(1);
          state_d = S_K0;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    w_q   <= w_d;
    j_q   <= j_d;
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    k_q   <= k_d;
    pos_q <= pos_d;
    oob_q <= oob_d;
    a_q   <= a_d;
    bnd_q <= bnd_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // The rewrite pass stays inside the range.
  a_k_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_K1) |-> (k_q <= r_pos))
    else $error("rewrite index beyond range end");

  // No request is taken while a walk or a read is under way.
  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !in_ready_o)
    else $error("request taken while busy");

  // The S_RD state always produces a held result in the next cycle.
  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD) |=> out_valid_o)
    else $error("read result missing");

  // The scan position stays inside the row while scanning.
  a_scan_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_E0) |-> ((j_q >= PW'(1)) && (j_q < wm1)))
    else $error("scan position outside row");

endmodule
